>>> hdl/lpd_pkg.sv
package lpd_pkg;

  localparam logic [1:0] MODE_UNDECIDED = 2'd0;
  localparam logic [1:0] MODE_PRELEN    = 2'd1;
  localparam logic [1:0] MODE_LINE      = 2'd2;

  localparam logic [1:0] PHASE_SKIP   = 2'd0;
  localparam logic [1:0] PHASE_DIGITS = 2'd1;
  localparam logic [1:0] PHASE_DONE   = 2'd2;

  localparam int unsigned LenW = 27;
  localparam logic [LenW-1:0] LEN_MAX = 27'd99999999;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  typedef struct packed {
    logic [1:0]      phase;
    logic [LenW-1:0] acc;
    logic            neg;
  } hdr_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

endpackage

>>> hdl/lpd_hdr_parse.sv
module lpd_hdr_parse
  import lpd_pkg::*;
(
  input  hdr_t       hdr_i,
  input  logic [7:0] byte_i,
  output hdr_t       hdr_o
);

  logic [LenW+3:0] times_ten;
  logic [LenW+3:0] sum;
  logic [7:0]      digit;

  assign digit     = byte_i - CHAR_ZERO;
  assign times_ten = {1'b0, hdr_i.acc, 3'b000} + {3'b000, hdr_i.acc, 1'b0};
  assign sum       = times_ten + {{(LenW-4){1'b0}}, digit};

  always_comb begin
    hdr_o = hdr_i;
    if (hdr_i.phase != PHASE_DONE) begin
      if (is_digit(byte_i)) begin
        // saturate the magnitude
        hdr_o.acc   = (sum > {4'd0, LEN_MAX}) ? LEN_MAX : sum[LenW-1:0];
        hdr_o.phase = PHASE_DIGITS;
      end else if (hdr_i.phase == PHASE_SKIP && is_space(byte_i)) begin
        hdr_o.phase = PHASE_SKIP;
      end else if (hdr_i.phase == PHASE_SKIP &&
                   (byte_i == CHAR_PLUS || byte_i == CHAR_MINUS)) begin
        hdr_o.neg   = (byte_i == CHAR_MINUS);
        hdr_o.phase = PHASE_DIGITS;
      end else begin
        hdr_o.phase = PHASE_DONE;
      end
    end
  end

endmodule

>>> hdl/length_prefixed_deframer.sv
// Each accepted byte and its flags are captured in the output register.
// Throughput: one byte per cycle unless the output stalls; the result register
// frees itself when the held item is taken, so input and output can move in the same cycle.
// Reset (rst_ni low, asynchronous): mode undecided, header parser cleared,
// no body pending, auto-detect off, result register empty.
module length_prefixed_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned HEADER_DIGITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            auto_detect_we_i,
  input  logic            auto_detect_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            in_payload_o,
  output logic            frame_end_o,
  output logic            status_o,
  output logic [LenW-1:0] frame_length_o,
  output logic            line_mode_o
);

  localparam logic [4:0] HdrLast = (HEADER_DIGITS == 0) ? 5'd1 : 5'(HEADER_DIGITS);

  localparam hdr_t HDR_CLEAR = '{phase: PHASE_SKIP, acc: '0, neg: 1'b0};

  logic            auto_q;
  logic [1:0]      mode_q, mode_d, mode_eff;
  logic [3:0]      pos_q, pos_d, pos_inc;
  hdr_t            hdr_q, hdr_d, hdr_parsed;
  logic [LenW-1:0] rem_q, rem_d;

  logic            out_valid_q;
  logic [7:0]      byte_q;
  logic            payload_q, payload_d;
  logic            fend_q, fend_d;
  logic            status_q, status_d;
  logic [LenW-1:0] flen_q, flen_d;
  logic            line_q;

  logic accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  lpd_hdr_parse u_parse (
    .hdr_i  (hdr_q),
    .byte_i (data_byte_i),
    .hdr_o  (hdr_parsed)
  );

  assign pos_inc = pos_q + 4'd1;

  always_comb begin
    mode_eff = mode_q;
    if (mode_q == MODE_UNDECIDED && auto_q && pos_q == 4'd0 && rem_q == '0) begin
      mode_eff = is_digit(data_byte_i) ? MODE_PRELEN : MODE_LINE;
    end
  end

  always_comb begin
    mode_d    = mode_eff;
    pos_d     = pos_q;
    hdr_d     = hdr_q;
    rem_d     = rem_q;
    payload_d = 1'b0;
    fend_d    = 1'b0;
    status_d  = 1'b0;
    flen_d    = '0;
    if (mode_eff == MODE_LINE) begin
      payload_d = 1'b1;
      fend_d    = (data_byte_i == CHAR_NL);
    end else if (rem_q != '0) begin
      payload_d = 1'b1;
      flen_d    = hdr_q.acc;
      rem_d     = rem_q - LenW'(1);
      if (rem_q == LenW'(1)) begin
        fend_d = 1'b1;
        pos_d  = 4'd0;
        hdr_d  = HDR_CLEAR;
      end
    end else begin
      hdr_d = hdr_parsed;
      pos_d = pos_inc;
      if ({1'b0, pos_inc} >= HdrLast) begin
        pos_d = 4'd0;
        if (hdr_parsed.neg || hdr_parsed.acc == '0) begin
          status_d = 1'b1;
          hdr_d    = HDR_CLEAR;
        end else begin
          // keep the length for the body bytes, rearm the parser
          flen_d      = hdr_parsed.acc;
          rem_d       = hdr_parsed.acc;
          hdr_d.phase = PHASE_SKIP;
          hdr_d.neg   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q      <= 1'b0;
      mode_q      <= MODE_UNDECIDED;
      pos_q       <= 4'd0;
      hdr_q       <= HDR_CLEAR;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (auto_detect_we_i) begin
        auto_q <= auto_detect_i;
      end
      if (accept) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        hdr_q  <= hdr_d;
        rem_q  <= rem_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q    <= data_byte_i;
      payload_q <= payload_d;
      fend_q    <= fend_d;
      status_q  <= status_d;
      flen_q    <= flen_d;
      line_q    <= (mode_eff == MODE_LINE);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign in_payload_o   = payload_q;
  assign frame_end_o    = fend_q;
  assign status_o       = status_q;
  assign frame_length_o = flen_q;
  assign line_mode_o    = line_q;

endmodule
